@@ hdl/wjh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wjh_pkg
// Shared widths, request and status codes and types of the weighted joint
// histogram unit.
// ----------------------------------------------------------------------------
package wjh_pkg;

	localparam int BIN_W     = 40;
	localparam int WGT_W     = 16;
	localparam int LABEL_W   = 4;
	localparam int COL_W     = 4;
	localparam int ADDR_W    = 12;
	localparam int COORD_W   = 6;
	localparam int GRID_W    = 5;
	localparam int YZ_W      = 2 * GRID_W;
	localparam int LIN_W     = 17;
	localparam int REQ_W     = 2;
	localparam int ST_W      = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ACC   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_FALLBACK = 2'd1;
	localparam logic [ST_W-1:0] ST_SAT      = 2'd2;
	localparam logic [ST_W-1:0] ST_BAD      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z = 2'd2;

	localparam logic [GRID_W-1:0] GRID_RESET = 5'd16;
	localparam logic [BIN_W-1:0]  BIN_MAX    = {BIN_W{1'b1}};

	typedef struct packed {
		logic             in_grid;
		logic [LIN_W-1:0] lin;
	} lin_res_t;

endpackage
`default_nettype wire

@@ hdl/weighted_joint_histogram_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_joint_histogram_unit
// Weighted joint histogram engine over a node label volume and a bin store.
// ----------------------------------------------------------------------------
// One transaction is handled at a time, through the label memory and the
// histogram memory, each with a registered read port. A load or a bad
// request goes from decode to the result; a read or an out-of-grid
// accumulate reads one bin first; an in-grid accumulate does a label read,
// then a bin read, then the write-back. req_ready is high again from the edge
// that raises rsp_valid. A clear sweeps the histogram one bin a cycle. A
// stalled result adds its wait. After reset the same sweep runs with
// req_ready low; configuration writes are taken at any time. A result may
// wait in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module weighted_joint_histogram_unit #(
	parameter int NODE_BINS    = 16,
	parameter int VOXEL_BINS   = 16,
	parameter int VOLUME_WORDS = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wjh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wjh_pkg::GRID_W-1:0]          cfg_data,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [wjh_pkg::REQ_W-1:0]           req_type,
	input  logic [wjh_pkg::ADDR_W-1:0]          grid_address,
	input  logic [wjh_pkg::LABEL_W-1:0]         node_label,
	input  logic [wjh_pkg::COL_W-1:0]           voxel_bin,
	input  logic signed [wjh_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [wjh_pkg::COORD_W-1:0]  y_coord,
	input  logic signed [wjh_pkg::COORD_W-1:0]  z_coord,
	input  logic [wjh_pkg::WGT_W-1:0]           weight,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [wjh_pkg::BIN_W-1:0]           bin_value,
	output logic [wjh_pkg::ST_W-1:0]            status
);
	import wjh_pkg::*;

	localparam int HIST_DEPTH = NODE_BINS * VOXEL_BINS;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int VOL_AW     = $clog2(VOLUME_WORDS);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_LDATA = 3'd3;
	localparam logic [2:0] S_HDATA = 3'd4;
	localparam logic [2:0] S_CLR   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]         state_q;
	logic [HIST_AW-1:0] clr_ptr_q;
	logic               rsp_valid_q;
	logic [GRID_W-1:0]  grid_x_q;
	logic [GRID_W-1:0]  grid_y_q;
	logic [GRID_W-1:0]  grid_z_q;
	logic [YZ_W-1:0]    yz_q;

	logic [REQ_W-1:0]          req_q;
	logic [ADDR_W-1:0]         addr_q;
	logic [LABEL_W-1:0]        label_q;
	logic [COL_W-1:0]          col_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic signed [COORD_W-1:0] z_q;
	logic [WGT_W-1:0]          weight_q;
	logic [HIST_AW-1:0]        idx_q;
	logic [BIN_W-1:0]          res_val_q;
	logic [ST_W-1:0]           res_st_q;
	logic [BIN_W-1:0]          bin_value_q;
	logic [ST_W-1:0]           status_q;

	logic [LABEL_W-1:0] label_mem [VOLUME_WORDS];
	logic [BIN_W-1:0]   hist_mem  [HIST_DEPTH];
	logic [LABEL_W-1:0] lbl_rd;
	logic [BIN_W-1:0]   hist_rd;

	logic               lbl_we;
	logic               lbl_re;
	logic [VOL_AW-1:0]  lbl_waddr;
	logic [VOL_AW-1:0]  lbl_raddr;
	logic               hist_we;
	logic               hist_re;
	logic [HIST_AW-1:0] hist_waddr;
	logic [HIST_AW-1:0] hist_raddr;
	logic [BIN_W-1:0]   hist_wdata;

	lin_res_t           lin_res;
	logic [LIN_W-1:0]   addr_ext;
	logic               load_bad;
	logic               row_bad;
	logic               col_bad;
	logic [LABEL_W-1:0] lbl_row;
	logic [BIN_W:0]     sum_ext;
	logic               sum_sat_flag;
	logic [BIN_W-1:0]   sum_sat;
	logic               clr_last;
	logic               out_free;

	function automatic logic [HIST_AW-1:0] bin_index(input logic [LABEL_W-1:0] row,
			input logic [COL_W-1:0] col);
		bin_index = HIST_AW'(32'(row) * VOXEL_BINS + 32'(col));
	endfunction

	wjh_lin #(
		.VOLUME_WORDS(VOLUME_WORDS)
	) u_lin (
		.x   (x_q),
		.y   (y_q),
		.z   (z_q),
		.gx  (grid_x_q),
		.gy  (grid_y_q),
		.gz  (grid_z_q),
		.gyz (yz_q),
		.res (lin_res)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign bin_value = bin_value_q;
	assign status    = status_q;

	assign addr_ext  = LIN_W'(addr_q);
	assign load_bad  = (32'(addr_q) >= VOLUME_WORDS) || (32'(label_q) >= NODE_BINS);
	assign row_bad   = (32'(label_q) >= NODE_BINS);
	assign col_bad   = (32'(col_q) >= VOXEL_BINS);
	assign lbl_row   = (32'(lbl_rd) >= NODE_BINS) ? '0 : lbl_rd;
	assign lbl_waddr = addr_ext[VOL_AW-1:0];
	assign lbl_raddr = lin_res.lin[VOL_AW-1:0];

	assign sum_ext      = {1'b0, hist_rd} + (BIN_W+1)'(weight_q);
	assign sum_sat_flag = sum_ext[BIN_W];
	assign sum_sat      = sum_sat_flag ? BIN_MAX : sum_ext[BIN_W-1:0];

	assign clr_last = (clr_ptr_q == HIST_AW'(HIST_DEPTH - 1));
	assign out_free = !rsp_valid_q || rsp_ready;

	// memory port control
	always_comb begin
		lbl_we     = 1'b0;
		lbl_re     = 1'b0;
		hist_we    = 1'b0;
		hist_re    = 1'b0;
		hist_raddr = bin_index(label_q, col_q);
		hist_waddr = idx_q;
		hist_wdata = sum_sat;
		unique case (state_q)
			S_INIT, S_CLR: begin
				hist_we    = 1'b1;
				hist_waddr = clr_ptr_q;
				hist_wdata = '0;
			end
			S_DEC: begin
				case (req_q)
					REQ_LOAD: lbl_we = !load_bad;
					REQ_READ: hist_re = !(row_bad || col_bad);
					REQ_ACC: begin
						if (!col_bad) begin
							if (lin_res.in_grid) begin
								lbl_re = 1'b1;
							end else begin
								// out of grid falls back to row 0
								hist_re    = 1'b1;
								hist_raddr = bin_index('0, col_q);
							end
						end
					end
					default: ;
				endcase
			end
			S_LDATA: begin
				hist_re    = 1'b1;
				hist_raddr = bin_index(lbl_row, col_q);
			end
			S_HDATA: hist_we = (req_q == REQ_ACC);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (lbl_we) begin
			label_mem[lbl_waddr] <= label_q;
		end
		if (lbl_re) begin
			lbl_rd <= label_mem[lbl_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		if (hist_re) begin
			hist_rd <= hist_mem[hist_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_ptr_q   <= '0;
			rsp_valid_q <= 1'b0;
			grid_x_q    <= GRID_RESET;
			grid_y_q    <= GRID_RESET;
			grid_z_q    <= GRID_RESET;
			yz_q        <= YZ_W'(GRID_RESET) * YZ_W'(GRID_RESET);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_GRID_X: grid_x_q <= cfg_data;
					CFG_GRID_Y: grid_y_q <= cfg_data;
					CFG_GRID_Z: grid_z_q <= cfg_data;
					default: ;
				endcase
			end
			yz_q <= YZ_W'(grid_y_q) * YZ_W'(grid_z_q);

			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_INIT: begin
					clr_ptr_q <= clr_last ? '0 : clr_ptr_q + HIST_AW'(1);
					if (clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					case (req_q)
						REQ_CLEAR: state_q <= S_CLR;
						REQ_READ:  state_q <= (row_bad || col_bad) ? S_DONE : S_HDATA;
						REQ_ACC: begin
							if (col_bad) begin
								state_q <= S_DONE;
							end else if (lin_res.in_grid) begin
								state_q <= S_LDATA;
							end else begin
								state_q <= S_HDATA;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_LDATA: state_q <= S_HDATA;
				S_HDATA: state_q <= S_DONE;
				S_CLR: begin
					clr_ptr_q <= clr_last ? '0 : clr_ptr_q + HIST_AW'(1);
					if (clr_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q    <= req_type;
			addr_q   <= grid_address;
			label_q  <= node_label;
			col_q    <= voxel_bin;
			x_q      <= x_coord;
			y_q      <= y_coord;
			z_q      <= z_coord;
			weight_q <= weight;
		end
		if (hist_re) begin
			idx_q <= hist_raddr;
		end
		if (state_q == S_DEC) begin
			res_val_q <= '0;
			case (req_q)
				REQ_LOAD:  res_st_q <= load_bad ? ST_BAD : ST_OK;
				REQ_READ:  res_st_q <= (row_bad || col_bad) ? ST_BAD : ST_OK;
				REQ_ACC: begin
					if (col_bad) begin
						res_st_q <= ST_BAD;
					end else begin
						res_st_q <= lin_res.in_grid ? ST_OK : ST_FALLBACK;
					end
				end
				default: res_st_q <= ST_OK;
			endcase
		end
		if (state_q == S_HDATA) begin
			if (req_q == REQ_ACC) begin
				res_val_q <= sum_sat;
				if (sum_sat_flag) begin
					res_st_q <= ST_SAT;
				end
			end else begin
				res_val_q <= hist_rd;
			end
		end
		if (state_q == S_DONE && out_free) begin
			bin_value_q <= res_val_q;
			status_q    <= res_st_q;
		end
	end

endmodule
`default_nettype wire

@@ hdl/wjh_lin.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wjh_lin
// Grid check and linearization x*ny*nz + y*nz + z of node coordinates.
// ----------------------------------------------------------------------------
module wjh_lin #(
	parameter int VOLUME_WORDS = 4096
) (
	input  logic signed [wjh_pkg::COORD_W-1:0] x,
	input  logic signed [wjh_pkg::COORD_W-1:0] y,
	input  logic signed [wjh_pkg::COORD_W-1:0] z,
	input  logic [wjh_pkg::GRID_W-1:0]         gx,
	input  logic [wjh_pkg::GRID_W-1:0]         gy,
	input  logic [wjh_pkg::GRID_W-1:0]         gz,
	input  logic [wjh_pkg::YZ_W-1:0]           gyz,
	output wjh_pkg::lin_res_t                  res
);
	import wjh_pkg::*;

	logic [LIN_W-1:0] x_term;
	logic [LIN_W-1:0] y_term;
	logic [LIN_W-1:0] lin;
	logic             coords_ok;

	// gyz is the registered ny*nz product
	assign x_term = LIN_W'(x[GRID_W-1:0]) * LIN_W'(gyz);
	assign y_term = LIN_W'(y[GRID_W-1:0]) * LIN_W'(gz);
	assign lin    = x_term + y_term + LIN_W'(z[GRID_W-1:0]);

	assign coords_ok = !x[COORD_W-1] && !y[COORD_W-1] && !z[COORD_W-1] &&
		(x[GRID_W-1:0] < gx) && (y[GRID_W-1:0] < gy) && (z[GRID_W-1:0] < gz);

	assign res.in_grid = coords_ok && (32'(lin) < VOLUME_WORDS);
	assign res.lin     = lin;

endmodule
`default_nettype wire

@@ hdl/wjh_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wjh_checker
// Port-level checks of the weighted joint histogram unit, bound to the top.
// ----------------------------------------------------------------------------
module wjh_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [wjh_pkg::BIN_W-1:0] bin_value,
	input logic [wjh_pkg::ST_W-1:0]  status
);
	import wjh_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(bin_value) && $stable(status))
		else $error("result changed while stalled");

	// one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_SAT) |-> (bin_value == BIN_MAX))
		else $error("saturated result not at maximum");

	a_bad_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_BAD) |-> (bin_value == '0))
		else $error("bad request returned nonzero bin");

endmodule

bind weighted_joint_histogram_unit wjh_checker u_wjh_checker (.*);
`default_nettype wire
